/* hw/rtl/tolerant_duplicate_filter_assert.svh */
// ----------------------------------------------------------------------------
// tolerant_duplicate_filter_assert.svh
// Assertion macros for the tolerant duplicate filter. Both macros expect
// clk_i and rst_ni in scope and are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TOLERANT_DUPLICATE_FILTER_ASSERT_SVH
`define TOLERANT_DUPLICATE_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tdf_pkg.sv */
// ----------------------------------------------------------------------------
// tdf_pkg
// Constants, types and helper functions of the tolerant duplicate filter.
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int MAX_ENTRIES   = 64;
  localparam int ANGLE_BITS    = 11;
  localparam int IN_ANGLE_BITS = 10;
  localparam int NUM_ANGLES    = 7;
  localparam int NUM_FIRST     = 4;
  localparam int NUM_SECOND    = NUM_ANGLES - NUM_FIRST;
  localparam int HELD_BITS     = 7;

  localparam int AddrW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW     = $clog2(MAX_ENTRIES + 1);
  localparam int InDataW  = ((NUM_ANGLES * IN_ANGLE_BITS + 7) / 8) * 8;
  localparam int OutDataW = ((HELD_BITS + 7) / 8) * 8;
  localparam int FirstW   = NUM_FIRST * ANGLE_BITS;
  localparam int SecondW  = NUM_SECOND * ANGLE_BITS;

  // Result status codes
  localparam logic [1:0] STATUS_DUP     = 2'd0;
  localparam logic [1:0] STATUS_NEW     = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_CLEARED = 2'd3;

  // Input function codes
  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef logic signed [ANGLE_BITS-1:0]    angle_t;
  typedef logic signed [IN_ANGLE_BITS-1:0] in_angle_t;

  // Sign-extend the input angle, then keep ANGLE_BITS (wraps if narrower).
  function automatic angle_t to_angle(input in_angle_t a);
    logic signed [15:0] wide;
    wide = 16'(a);
    return wide[ANGLE_BITS-1:0];
  endfunction

  // True when a - b lies in {-1, 0, 1}.
  function automatic logic is_near(input angle_t a, input angle_t b);
    logic [ANGLE_BITS:0] diff;
    diff = {a[ANGLE_BITS-1], a} - {b[ANGLE_BITS-1], b};
    return (diff == '0) || (diff == (ANGLE_BITS+1)'(1)) || (diff == '1);
  endfunction

  // Report the count masked to the output field width.
  function automatic logic [HELD_BITS-1:0] held_out(input logic [CntW-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[HELD_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/tolerant_duplicate_filter.sv */
// ----------------------------------------------------------------------------
// tolerant_duplicate_filter
// Table of seven-angle tuples that rejects near-duplicates and appends new ones.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one transfer is one item. tuser is the function
//   (0 check and insert, 1 clear), tdata carries the seven angles.
//   Output stream (m_axis): exactly one transfer per item. tuser is the status
//   (near-duplicate, new and stored, new but table full, cleared), tdata the
//   number of stored tuples after the item.
//   Flow: a clear skips the scan and goes straight to the response state. A check
//   reads and compares the stored tuples in order and ends the scan early when
//   a match is found. The single read port of the tuple memories sets the scan
//   length: one stored tuple is read and compared per cycle. The next input
//   transfer is taken only once the previous result has moved to the output
//   register; one item is in flight at a time.
//   Reset empties the table at once (the count is cleared, no memory pass).
//   Stall: the result waits in the output register; the next item is taken
//   while it waits, and that item's result holds in the block until the
//   output register frees up.
// ----------------------------------------------------------------------------
module tolerant_duplicate_filter
  import tdf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: angle_delta0, angle_epsilon, angle_zeta, angle_alpha, angle_beta,
  //        angle_gamma, angle_delta1 (10 bits each from bit 0), zero padding
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: func
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: entries_held (bits 6:0), zero padding
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // tuser: status
  output logic [1:0]          m_axis_tuser_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     issue_q, issue_d;
  logic                rd_vld_q;
  logic [1:0]          res_status_q, res_status_d;
  angle_t              ang_q [NUM_ANGLES];

  logic                m_valid_q;
  logic [1:0]          m_status_q;
  logic [HELD_BITS-1:0] m_held_q;

  // Tuple memories: one write port and one registered read port each
  logic [FirstW-1:0]   mem_first  [MAX_ENTRIES];
  logic [SecondW-1:0]  mem_second [MAX_ENTRIES];
  logic [FirstW-1:0]   rd_first_q;
  logic [SecondW-1:0]  rd_second_q;

  logic                in_xfer;
  logic                rd_en;
  logic                wr_en;
  logic                hit;
  logic                scan_done;
  logic                out_free;
  logic [NUM_ANGLES-1:0] near_vec;
  logic [FirstW-1:0]   wr_first;
  logic [SecondW-1:0]  wr_second;

  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // Compare the returned entry with the held tuple, angle by angle
  always_comb begin
    for (int k = 0; k < NUM_FIRST; k++) begin
      near_vec[k] = is_near(angle_t'(rd_first_q[k*ANGLE_BITS +: ANGLE_BITS]), ang_q[k]);
    end
    for (int k = 0; k < NUM_SECOND; k++) begin
      near_vec[NUM_FIRST+k] = is_near(angle_t'(rd_second_q[k*ANGLE_BITS +: ANGLE_BITS]),
                                      ang_q[NUM_FIRST+k]);
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_FIRST; k++) begin
      wr_first[k*ANGLE_BITS +: ANGLE_BITS] = ang_q[k];
    end
    for (int k = 0; k < NUM_SECOND; k++) begin
      wr_second[k*ANGLE_BITS +: ANGLE_BITS] = ang_q[NUM_FIRST+k];
    end
  end

  // Issue one read per cycle over the stored entries; a hit ends the scan.
  // Reads address entries below the count and the write goes to the count
  // itself after the scan, so a read and a write never meet on one entry.
  assign rd_en     = (state_q == ST_SCAN) && (issue_q != count_q) && !hit;
  assign hit       = rd_vld_q && (&near_vec);
  assign scan_done = (state_q == ST_SCAN) && (hit || ((issue_q == count_q) && !rd_vld_q));
  assign wr_en     = scan_done && !hit && (count_q != CntW'(MAX_ENTRIES));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    res_status_d = res_status_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          issue_d = '0;
          if (s_axis_tuser_i == FUNC_CLEAR) begin
            count_d      = '0;
            res_status_d = STATUS_CLEARED;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_d = issue_q + CntW'(1);
        end
        if (scan_done) begin
          state_d = ST_RESP;
          if (hit) begin
            res_status_d = STATUS_DUP;
          end else if (wr_en) begin
            res_status_d = STATUS_NEW;
            count_d      = count_q + CntW'(1);
          end else begin
            res_status_d = STATUS_FULL;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      issue_q      <= '0;
      rd_vld_q     <= 1'b0;
      res_status_q <= STATUS_DUP;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      issue_q      <= issue_d;
      rd_vld_q     <= rd_en;
      res_status_q <= res_status_d;
      if (state_q == ST_RESP && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the tuple of the item in flight and the result
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int k = 0; k < NUM_ANGLES; k++) begin
        ang_q[k] <= to_angle(in_angle_t'(s_axis_tdata_i[k*IN_ANGLE_BITS +: IN_ANGLE_BITS]));
      end
    end
    if (state_q == ST_RESP && out_free) begin
      m_status_q <= res_status_q;
      m_held_q   <= held_out(count_q);
    end
  end

  // Tuple memories
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_first[count_q[AddrW-1:0]]  <= wr_first;
      mem_second[count_q[AddrW-1:0]] <= wr_second;
    end
    if (rd_en) begin
      rd_first_q  <= mem_first[issue_q[AddrW-1:0]];
      rd_second_q <= mem_second[issue_q[AddrW-1:0]];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = OutDataW'(m_held_q);

`include "tolerant_duplicate_filter_assert.svh"

  `TDF_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CntW'(MAX_ENTRIES), "entry count above table size")
  `TDF_ASSERT_SAME(a_wr_after_scan, wr_en, (state_q == ST_SCAN) && !rd_en, "tuple write outside scan end")
  `TDF_ASSERT_NEXT(a_check_scans, in_xfer && (s_axis_tuser_i == FUNC_CHECK), state_q == ST_SCAN, "check item did not start a scan")
  `TDF_ASSERT_NEXT(a_clear_empties, in_xfer && (s_axis_tuser_i == FUNC_CLEAR), count_q == '0, "clear did not empty the table")

endmodule
